>>> rtl/core/mnrpn_pkg.sv
package mnrpn_pkg;

    // Channel store
    localparam int NUM_CHANNELS = 16;
    localparam int CHAN_IDX_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // NRPN controller numbers
    localparam logic [6:0] CC_VALUE_HI = 7'd6;
    localparam logic [6:0] CC_VALUE_LO = 7'd38;
    localparam logic [6:0] CC_PARAM_LO = 7'd98;
    localparam logic [6:0] CC_PARAM_HI = 7'd99;

    // Arrival flag bits
    localparam logic [3:0] FLAG_PARAM_HI = 4'b0001;
    localparam logic [3:0] FLAG_PARAM_LO = 4'b0010;
    localparam logic [3:0] FLAG_VALUE_HI = 4'b0100;
    localparam logic [3:0] FLAG_VALUE_LO = 4'b1000;
    localparam logic [3:0] FLAGS_PARAM   = 4'b0011;
    localparam logic [3:0] FLAGS_ALL     = 4'b1111;

    // Command queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [3:0] chan;
        logic [6:0] ctrl_num;
        logic [6:0] data_val;
    } msg_t;

    typedef struct packed {
        logic        nrpn_part;
        logic        complete;
        logic [13:0] param_number;
        logic [13:0] param_value;
    } result_t;

    typedef enum logic [2:0] {
        OP_NONE     = 3'd0,
        OP_PARAM_HI = 3'd1,
        OP_PARAM_LO = 3'd2,
        OP_VALUE_HI = 3'd3,
        OP_VALUE_LO = 3'd4
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [CHAN_IDX_W-1:0] chan_idx;
        logic [6:0]            data;
    } cmd_t;

    typedef struct packed {
        logic [6:0] param_hi;
        logic [6:0] param_lo;
        logic [6:0] value_hi;
        logic [6:0] value_lo;
        logic [3:0] flags;
    } entry_t;

endpackage

>>> rtl/core/mnrpn_front.sv
module mnrpn_front (
    input  logic                msg_valid,
    output logic                msg_ready,
    input  mnrpn_pkg::msg_t     msg,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output mnrpn_pkg::cmd_t     cmd
);
    import mnrpn_pkg::*;

    logic in_range;

    // Channel range check
    assign in_range = ({1'b0, msg.chan} < 5'(NUM_CHANNELS));

    // Decode controller into an operation
    always_comb
    begin
        cmd.op       = OP_NONE;
        cmd.chan_idx = msg.chan[CHAN_IDX_W-1:0];
        cmd.data     = msg.data_val;
        if (in_range)
        begin
            case (msg.ctrl_num)
                CC_PARAM_HI: cmd.op = OP_PARAM_HI;
                CC_PARAM_LO: cmd.op = OP_PARAM_LO;
                CC_VALUE_HI: cmd.op = OP_VALUE_HI;
                CC_VALUE_LO: cmd.op = OP_VALUE_LO;
                default:     cmd.op = OP_NONE;
            endcase
        end
    end

    assign cmd_valid = msg_valid;
    assign msg_ready = cmd_ready;

endmodule

>>> rtl/core/mnrpn_fifo.sv
module mnrpn_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  mnrpn_pkg::cmd_t  wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output mnrpn_pkg::cmd_t  rd_data
);
    import mnrpn_pkg::*;

    cmd_t                  entries_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  push, pop;

    assign wr_ready = (count_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entries_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue count beyond depth");

endmodule

>>> rtl/core/mnrpn_back.sv
module mnrpn_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  mnrpn_pkg::cmd_t     cmd,
    output logic                res_valid,
    input  logic                res_ready,
    output mnrpn_pkg::result_t  res
);
    import mnrpn_pkg::*;

    entry_t  store_reg [NUM_CHANNELS];
    entry_t  cur, upd;
    result_t res_reg, res_next;
    logic    res_valid_reg, res_valid_next;
    logic    pop, part, done;

    assign cmd_ready = !res_valid_reg || res_ready;
    assign pop       = cmd_valid && cmd_ready;
    assign cur       = store_reg[cmd.chan_idx];

    // Read-modify-write of the channel entry
    always_comb
    begin
        upd  = cur;
        part = 1'b0;
        done = 1'b0;
        case (cmd.op)
            OP_PARAM_HI:
            begin
                part         = 1'b1;
                upd.param_hi = cmd.data;
                upd.flags    = cur.flags | FLAG_PARAM_HI;
            end
            OP_PARAM_LO:
            begin
                part         = 1'b1;
                upd.param_lo = cmd.data;
                upd.flags    = cur.flags | FLAG_PARAM_LO;
            end
            OP_VALUE_HI:
            begin
                if ((cur.flags & FLAGS_PARAM) == FLAGS_PARAM)
                begin
                    part         = 1'b1;
                    upd.value_hi = cmd.data;
                    upd.flags    = cur.flags | FLAG_VALUE_HI;
                end
            end
            OP_VALUE_LO:
            begin
                if ((cur.flags & FLAGS_PARAM) == FLAGS_PARAM)
                begin
                    part         = 1'b1;
                    upd.value_lo = cmd.data;
                    upd.flags    = cur.flags | FLAG_VALUE_LO;
                end
            end
            default:
            begin
                part = 1'b0;
            end
        endcase

        // Full sequence: emit and clear the channel
        res_next              = '0;
        res_next.nrpn_part    = part;
        if (part && (upd.flags == FLAGS_ALL))
        begin
            done                  = 1'b1;
            res_next.complete     = 1'b1;
            res_next.param_number = {upd.param_hi, upd.param_lo};
            res_next.param_value  = {upd.value_hi, upd.value_lo};
            upd                   = '0;
        end
    end

    // Output register valid
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (pop)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (pop && part)
            begin
                store_reg[cmd.chan_idx] <= upd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_complete_is_part: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (!res_reg.complete || res_reg.nrpn_part))
        else $error("complete result not marked as NRPN");

    a_zero_unless_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.complete)
            |-> (res_reg.param_number == '0 && res_reg.param_value == '0))
        else $error("numbers nonzero on incomplete result");

    a_clear_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && done) |=> (store_reg[$past(cmd.chan_idx)].flags == '0))
        else $error("channel not cleared after completion");

    a_value_needs_param: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (((cur.flags & (FLAG_VALUE_HI | FLAG_VALUE_LO)) == '0)
                 || ((cur.flags & FLAGS_PARAM) == FLAGS_PARAM)))
        else $error("value byte stored without both parameter bytes");

endmodule

>>> rtl/core/midi_nrpn_assembler_unit.sv
// NRPN assembler for MIDI control-change items.
// Input channel msg (msg_valid/msg_ready): one control-change item with
// channel, controller number and 7-bit value. Output channel res
// (res_valid/res_ready): exactly one result item per input item, in order,
// carrying the NRPN flag, the complete flag and the 14-bit parameter number
// and value (both zero unless complete).
// An item passes the command queue and its result is held in the back end's
// output register; with the receiver ready, it is taken at the next edge.
// Throughput: one item per cycle while the receiver does not stall, set
// by the read-modify-write of the back end's 16-entry channel register file.
// A two-entry command queue sits between the decode front and the back end;
// the back end's output register lets it take a new item in the cycle its
// waiting result is taken. When the receiver stalls, the result holds, the
// queue fills and msg_ready drops once the queue is full.
// Reset clears every channel entry, the queue and the output valid at once;
// the block accepts items in the first cycle after reset.
module midi_nrpn_assembler_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                msg_valid,
    output logic                msg_ready,
    input  mnrpn_pkg::msg_t     msg,
    output logic                res_valid,
    input  logic                res_ready,
    output mnrpn_pkg::result_t  res
);
    import mnrpn_pkg::*;

    logic front_valid, front_ready;
    cmd_t front_cmd;
    logic back_valid, back_ready;
    cmd_t back_cmd;

    mnrpn_front u_front (
        .msg_valid (msg_valid),
        .msg_ready (msg_ready),
        .msg       (msg),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    mnrpn_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_data  (front_cmd),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_data  (back_cmd)
    );

    mnrpn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

>>> verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mnrpn_pkg::*;

    localparam int NUM_RANDOM    = 800;
    localparam int PHASE_ITEMS   = 100;
    localparam int MAX_GAP       = 18;
    localparam int HOLD_CYCLES   = 80;
    localparam int BURST_ITEMS   = 24;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 2000;

    localparam result_t NO_RES   = {1'b0, 1'b0, 14'd0, 14'd0};
    localparam result_t PART_RES = {1'b1, 1'b0, 14'd0, 14'd0};
    localparam result_t ZERO_SET = {1'b1, 1'b1, 14'd0, 14'd0};
    localparam result_t FULL_SET = {1'b1, 1'b1, 14'h3FFF, 14'h3FFF};

    // One row of the directed table; chk marks a typed-in expectation
    typedef struct packed {
        logic [3:0] chan;
        logic [6:0] ctrl_num;
        logic [6:0] data_val;
        bit         chk;
        result_t    want;
    } stim_row_t;

    typedef struct packed {
        bit      chk;
        result_t want;
    } pinned_t;

    logic    clk;
    logic    rst_n     = 1'b0;
    logic    msg_valid = 1'b0;
    logic    msg_ready;
    msg_t    msg       = '0;
    logic    res_valid;
    logic    res_ready = 1'b0;
    result_t res;

    // Predictor copy of the per-channel store
    logic [6:0] pm_hi     [NUM_CHANNELS] = '{default: '0};
    logic [6:0] pm_lo     [NUM_CHANNELS] = '{default: '0};
    logic [6:0] vl_hi     [NUM_CHANNELS] = '{default: '0};
    logic [6:0] vl_lo     [NUM_CHANNELS] = '{default: '0};
    logic [3:0] arr_flags [NUM_CHANNELS] = '{default: '0};

    // Stimulus-side progress of well-formed sequences per channel
    int unsigned seq_step    [NUM_CHANNELS] = '{default: 0};
    bit          param_first [NUM_CHANNELS] = '{default: 1'b0};
    bit          value_first [NUM_CHANNELS] = '{default: 1'b0};

    result_t exp_q[$];
    pinned_t pinned_q[$];
    int      errors   = 0;
    int      idle_cnt = 0;
    bit      idle_on  = 1'b1;
    bit      hold_req = 1'b0;

    stim_row_t dir_table [0:24] = '{
        // value bytes before any parameter byte are ignored
        '{4'd0,  CC_VALUE_HI, 7'd5,   1'b1, NO_RES},
        '{4'd0,  CC_VALUE_LO, 7'd127, 1'b1, NO_RES},
        // unrelated controllers at the field extremes
        '{4'd0,  7'd0,        7'd0,   1'b1, NO_RES},
        '{4'd15, 7'd127,      7'd127, 1'b1, NO_RES},
        // all-ones sequence, with a value byte after only one param byte
        '{4'd15, CC_PARAM_HI, 7'd127, 1'b1, PART_RES},
        '{4'd15, CC_VALUE_HI, 7'd3,   1'b1, NO_RES},
        '{4'd15, CC_PARAM_LO, 7'd127, 1'b1, PART_RES},
        '{4'd15, CC_VALUE_HI, 7'd127, 1'b1, PART_RES},
        '{4'd15, CC_VALUE_LO, 7'd127, 1'b1, FULL_SET},
        // channel was cleared by the completion
        '{4'd15, CC_VALUE_LO, 7'd9,   1'b1, NO_RES},
        // all-zeros sequence in reverse byte order
        '{4'd0,  CC_PARAM_LO, 7'd0,   1'b1, PART_RES},
        '{4'd0,  CC_PARAM_HI, 7'd0,   1'b1, PART_RES},
        '{4'd0,  CC_VALUE_LO, 7'd0,   1'b1, PART_RES},
        '{4'd0,  CC_VALUE_HI, 7'd0,   1'b1, ZERO_SET},
        // repeated bytes and two channels interleaved
        '{4'd5,  CC_PARAM_HI, 7'd1,   1'b1, PART_RES},
        '{4'd5,  CC_PARAM_HI, 7'd2,   1'b1, PART_RES},
        '{4'd9,  CC_PARAM_HI, 7'd127, 1'b1, PART_RES},
        '{4'd5,  CC_PARAM_LO, 7'd64,  1'b1, PART_RES},
        '{4'd5,  CC_VALUE_HI, 7'd10,  1'b0, NO_RES},
        '{4'd5,  CC_VALUE_HI, 7'd11,  1'b0, NO_RES},
        '{4'd9,  CC_PARAM_LO, 7'd1,   1'b0, NO_RES},
        '{4'd5,  7'd7,        7'd50,  1'b1, NO_RES},
        '{4'd5,  CC_VALUE_LO, 7'd127, 1'b0, NO_RES},
        '{4'd9,  CC_VALUE_LO, 7'd0,   1'b0, NO_RES},
        '{4'd9,  CC_VALUE_HI, 7'd127, 1'b0, NO_RES}
    };

    midi_nrpn_assembler_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_ready (msg_ready),
        .msg       (msg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Expected result of one item; updates the predictor's store
    function automatic result_t predict_nrpn(input msg_t m);
        result_t r;
        int      c;
        r = NO_RES;
        c = int'(m.chan);
        if (c < NUM_CHANNELS)
        begin
            case (m.ctrl_num)
                CC_PARAM_HI:
                begin
                    r.nrpn_part  = 1'b1;
                    pm_hi[c]     = m.data_val;
                    arr_flags[c] = arr_flags[c] | FLAG_PARAM_HI;
                end
                CC_PARAM_LO:
                begin
                    r.nrpn_part  = 1'b1;
                    pm_lo[c]     = m.data_val;
                    arr_flags[c] = arr_flags[c] | FLAG_PARAM_LO;
                end
                CC_VALUE_HI, CC_VALUE_LO:
                begin
                    if ((arr_flags[c] & FLAGS_PARAM) == FLAGS_PARAM)
                    begin
                        r.nrpn_part = 1'b1;
                        if (m.ctrl_num == CC_VALUE_HI)
                        begin
                            vl_hi[c]     = m.data_val;
                            arr_flags[c] = arr_flags[c] | FLAG_VALUE_HI;
                        end
                        else
                        begin
                            vl_lo[c]     = m.data_val;
                            arr_flags[c] = arr_flags[c] | FLAG_VALUE_LO;
                        end
                        if (arr_flags[c] == FLAGS_ALL)
                        begin
                            r.complete     = 1'b1;
                            r.param_number = {pm_hi[c], pm_lo[c]};
                            r.param_value  = {vl_hi[c], vl_lo[c]};
                            pm_hi[c]       = '0;
                            pm_lo[c]       = '0;
                            vl_hi[c]       = '0;
                            vl_lo[c]       = '0;
                            arr_flags[c]   = '0;
                        end
                    end
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    // Random item: mostly well-formed sequences, the rest noise
    task automatic next_random_msg(output msg_t m);
        int unsigned c;
        c          = $urandom_range(0, NUM_CHANNELS - 1);
        m.chan     = 4'(c);
        m.data_val = 7'($urandom_range(0, 127));
        if ($urandom_range(0, 3) != 0)
        begin
            if (seq_step[c] == 0)
            begin
                param_first[c] = 1'($urandom_range(0, 1));
                value_first[c] = 1'($urandom_range(0, 1));
            end
            case (seq_step[c])
                0: m.ctrl_num = param_first[c] ? CC_PARAM_HI : CC_PARAM_LO;
                1: m.ctrl_num = param_first[c] ? CC_PARAM_LO : CC_PARAM_HI;
                2: m.ctrl_num = value_first[c] ? CC_VALUE_HI : CC_VALUE_LO;
                default: m.ctrl_num = value_first[c] ? CC_VALUE_LO : CC_VALUE_HI;
            endcase
            // occasionally repeat a byte instead of moving on
            if ($urandom_range(0, 9) != 0)
                seq_step[c] = (seq_step[c] + 1) % 4;
        end
        else if ($urandom_range(0, 1) != 0)
        begin
            m.ctrl_num = 7'($urandom_range(0, 127));
        end
        else
        begin
            // stray NRPN byte that breaks a sequence
            case ($urandom_range(0, 3))
                0: m.ctrl_num = CC_PARAM_HI;
                1: m.ctrl_num = CC_PARAM_LO;
                2: m.ctrl_num = CC_VALUE_HI;
                default: m.ctrl_num = CC_VALUE_LO;
            endcase
        end
    endtask

    // Offer one item after gap idle cycles; returns at the accepting edge
    task automatic offer(input msg_t m, input int gap, input bit chk, input result_t want);
        pinned_t p;
        if (gap > 0)
        begin
            msg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        p.chk  = chk;
        p.want = want;
        pinned_q.push_back(p);
        msg_valid <= 1'b1;
        msg       <= m;
        do
            @(posedge clk);
        while (!msg_ready);
    endtask

    function automatic int draw_gap();
        return idle_on ? int'($urandom_range(0, MAX_GAP)) : 0;
    endfunction

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch: expected %0d, actual %0d",
                     $time, field, want, got);
            errors++;
        end
    endtask

    // Sender: reset, directed table, then random phases
    initial
    begin : stimulus
        msg_t m;
        int   counted;
        int   ph;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_table[i])
        begin
            m.chan     = dir_table[i].chan;
            m.ctrl_num = dir_table[i].ctrl_num;
            m.data_val = dir_table[i].data_val;
            offer(m, draw_gap(), dir_table[i].chk, dir_table[i].want);
        end

        counted = 0;
        ph      = 0;
        while (counted < NUM_RANDOM)
        begin
            idle_on = (ph % 4 != 3);
            if (ph == 2)
            begin
                // receiver holds off while items keep coming back to back
                hold_req = 1'b1;
                repeat (BURST_ITEMS)
                begin
                    next_random_msg(m);
                    offer(m, 0, 1'b0, NO_RES);
                    counted++;
                end
            end
            if (ph == 4)
            begin
                // sender pauses until the block has drained
                msg_valid <= 1'b0;
                while (exp_q.size() != 0 || pinned_q.size() != 0)
                    @(posedge clk);
            end
            repeat (PHASE_ITEMS)
            begin
                next_random_msg(m);
                offer(m, draw_gap(), 1'b0, NO_RES);
                counted++;
            end
            ph++;
        end
        msg_valid <= 1'b0;

        while (exp_q.size() != 0 || pinned_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && exp_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Receiver: random stall per item, one long hold-off on request
    initial
    begin : receiver
        int stall;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = draw_gap();
                if (stall > 0)
                begin
                    res_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            res_ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_valid);
        end
    end

    // Scoreboard and watchdog: both handshakes sampled in one process
    always @(posedge clk)
    begin : scoreboard
        pinned_t p;
        result_t want;
        if (rst_n)
        begin
            if (msg_valid && msg_ready)
            begin
                p    = pinned_q.pop_front();
                want = predict_nrpn(msg);
                if (p.chk)
                    want = p.want;
                exp_q.push_back(want);
            end
            if (res_valid && res_ready)
            begin
                if (exp_q.size() == 0)
                begin
                    $display("%0t ns: result with nothing expected: expected none, actual %h",
                             $time, res);
                    errors++;
                end
                else
                begin
                    want = exp_q.pop_front();
                    check_field("nrpn_part", want.nrpn_part, res.nrpn_part);
                    check_field("complete", want.complete, res.complete);
                    check_field("param_number", want.param_number, res.param_number);
                    check_field("param_value", want.param_value, res.param_value);
                end
            end
            if ((msg_valid && msg_ready) || (res_valid && res_ready))
                idle_cnt <= 0;
            else if (idle_cnt + 1 >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
                idle_cnt <= idle_cnt + 1;
        end
    end

endmodule

>>> midi_nrpn_assembler_unit.f
rtl/core/mnrpn_pkg.sv
rtl/core/mnrpn_front.sv
rtl/core/mnrpn_fifo.sv
rtl/core/mnrpn_back.sv
rtl/core/midi_nrpn_assembler_unit.sv
verif/tb_top.sv
